@@ src/bis_pkg.sv @@
`timescale 1ns / 1ps

package bis_pkg;

    // Default number of cells in the store.
    localparam int unsigned BIS_CAPACITY = 128;

    // Field widths fixed by the interface.
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = 8;

    // Capacity limit after reset.
    localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd128;

    // Operation codes carried by the mode field of a request.
    typedef enum logic [2:0] {
        MODE_INSERT  = 3'd0,
        MODE_REMOVE  = 3'd1,
        MODE_QUERY   = 3'd2,
        MODE_RESTART = 3'd3,
        MODE_NEXT    = 3'd4
    } t_mode;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic              eval;    // compare the key and sample the iterator pick
        logic [DATA_W-1:0] key;     // value under test
        logic [CNT_W-1:0]  count;   // current element count
        logic [CNT_W-1:0]  iter;    // current iterator position
        logic              write;   // store the key at position count
        logic              shift;   // take the right neighbor's value where flagged
    } t_cell_ctrl;

endpackage

@@ src/bis_cell.sv @@
`timescale 1ns / 1ps

module bis_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                       i_clk,
    input  bis_pkg::t_cell_ctrl        i_ctrl,
    input  logic [bis_pkg::DATA_W-1:0] i_next_value,
    input  logic                       i_shift_here,
    output logic [bis_pkg::DATA_W-1:0] o_value,
    output logic                       o_match,
    output logic [bis_pkg::DATA_W-1:0] o_pick
);
    import bis_pkg::*;

    // Position of this cell, and whether the count field can reach it at all.
    localparam bit               IDX_REACH = (IDX < (1 << CNT_W));
    localparam logic [CNT_W-1:0] IDX_L     = CNT_W'(IDX);

    logic [DATA_W-1:0] r_value;
    logic              r_match;
    logic [DATA_W-1:0] r_pick;
    logic              occupied;

    // A cell holds a live element when its position is below the count.
    assign occupied = IDX_REACH && (i_ctrl.count > IDX_L);

    // Compare against the broadcast key and sample the entry under the iterator.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.eval) begin
            r_match <= occupied && (r_value == i_ctrl.key);
            if (occupied && (i_ctrl.iter == IDX_L)) begin
                r_pick <= r_value;
            end else begin
                r_pick <= '0;
            end
        end
    end

    // Append at the tail on insert, or close the gap on remove.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.write && IDX_REACH && (i_ctrl.count == IDX_L)) begin
            r_value <= i_ctrl.key;
        end else if (i_ctrl.shift && i_shift_here) begin
            r_value <= i_next_value;
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;
    assign o_pick  = r_pick;

endmodule

@@ src/bis_prefix.sv @@
`timescale 1ns / 1ps

module bis_prefix #(
    parameter int unsigned N = 128
) (
    input  logic [N-1:0] i_bits,
    output logic [N-1:0] o_prefix
);
    // Inclusive prefix OR, built as a log-depth network.
    localparam int unsigned LVLS = $clog2(N);

    logic [LVLS:0][N-1:0] lvl;

    assign lvl[0] = i_bits;

    // Each level folds in the value from a distance of twice the previous one.
    for (genvar k = 0; k < LVLS; k++) begin : g_lvl
        for (genvar i = 0; i < N; i++) begin : g_bit
            if (i >= (1 << k)) begin : g_fold
                assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1<<k)];
            end else begin : g_pass
                assign lvl[k+1][i] = lvl[k][i];
            end
        end
    end

    assign o_prefix = lvl[LVLS];

endmodule

@@ src/bounded_integer_set_store.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_stall   i_mode, i_element
// result    out        o_valid / i_stall   o_ok, o_element_out, o_count
// config    in         i_cfg_wr_en         i_cfg_wr_data (capacity limit)
//
// Each request passes through three steps: capture, a parallel compare in every cell,
// then commit of the update and the result. The next request is taken once the
// commit is done. The commit waits while a previous result is still stalled.
// Reset is synchronous and clears the count, the iterator and the limit; the
// cell contents are not cleared, since only cells below the count are read.

module bounded_integer_set_store #(
    parameter int unsigned CAPACITY = bis_pkg::BIS_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [2:0]                        i_mode,
    input  logic signed [bis_pkg::DATA_W-1:0] i_element,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_ok,
    output logic signed [bis_pkg::DATA_W-1:0] o_element_out,
    output logic [bis_pkg::CNT_W-1:0]         o_count,
    input  logic                              i_cfg_wr_en,
    input  logic [bis_pkg::CNT_W-1:0]         i_cfg_wr_data
);
    import bis_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_MATCH  = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state            r_state, n_state;
    t_mode             r_mode;
    logic [DATA_W-1:0] r_key;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_iter, n_iter;
    logic [CNT_W-1:0]  r_limit;
    logic              r_o_valid;
    logic              r_ok, n_ok;
    logic [DATA_W-1:0] r_elem, n_elem;

    t_cell_ctrl                    ctrl;
    logic [CAPACITY-1:0][DATA_W-1:0] cell_value;
    logic [CAPACITY-1:0][DATA_W-1:0] cell_pick;
    logic [DATA_W-1:0][CAPACITY-1:0] pick_t;
    logic [CAPACITY-1:0]           match_vec;
    logic [CAPACITY-1:0]           shift_vec;
    logic [DATA_W-1:0]             pick_data;
    logic                          found;
    logic                          room;
    logic                          accept;
    logic                          commit;
    logic                          do_write;
    logic                          do_shift;

    assign accept = i_valid && !o_stall;
    assign commit = (r_state == S_COMMIT) && !(r_o_valid && i_stall);
    assign o_stall = (r_state != S_IDLE);

    // Sequencer: capture, compare, commit.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= t_mode'(i_mode);
            r_key  <= i_element;
        end
    end

    // Capacity limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    // Broadcast to the row of cells.
    always_comb begin
        ctrl.eval  = (r_state == S_MATCH);
        ctrl.key   = r_key;
        ctrl.count = r_count;
        ctrl.iter  = r_iter;
        ctrl.write = do_write;
        ctrl.shift = do_shift;
    end

    // The row of cells; on a remove, each cell at or beyond the match takes its right neighbor's value.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] next_value;
        if (i == CAPACITY - 1) begin : g_last
            assign next_value = cell_value[i];
        end else begin : g_mid
            assign next_value = cell_value[i+1];
        end

        bis_cell #(
            .IDX(i)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_next_value(next_value),
            .i_shift_here(shift_vec[i]),
            .o_value     (cell_value[i]),
            .o_match     (match_vec[i]),
            .o_pick      (cell_pick[i])
        );

        for (genvar b = 0; b < DATA_W; b++) begin : g_bit
            assign pick_t[b][i] = cell_pick[i][b];
        end
    end

    // Cells at and beyond the matching position shift down on a remove.
    bis_prefix #(
        .N(CAPACITY)
    ) u_prefix (
        .i_bits  (match_vec),
        .o_prefix(shift_vec)
    );

    // Only the cell under the iterator drives a nonzero pick.
    always_comb begin
        for (int b = 0; b < DATA_W; b++) begin
            pick_data[b] = |pick_t[b];
        end
    end

    assign found = |match_vec;
    assign room  = (r_count < r_limit) && (32'(r_count) < CAPACITY);

    // Commit: state update and the result of this request.
    always_comb begin
        n_count  = r_count;
        n_iter   = r_iter;
        n_ok     = 1'b0;
        n_elem   = '0;
        do_write = 1'b0;
        do_shift = 1'b0;
        case (r_mode)
            MODE_INSERT: begin
                if (found) begin
                    n_ok = 1'b1;
                end else if (room) begin
                    do_write = commit;
                    n_count  = r_count + 8'd1;
                    n_ok     = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (found) begin
                    do_shift = commit;
                    n_count  = r_count - 8'd1;
                    n_ok     = 1'b1;
                end
            end
            MODE_QUERY: begin
                n_ok = found;
            end
            MODE_RESTART: begin
                n_iter = '0;
                n_ok   = 1'b1;
            end
            MODE_NEXT: begin
                if (r_iter < r_count) begin
                    n_elem = pick_data;
                    n_iter = r_iter + 8'd1;
                    n_ok   = 1'b1;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_iter  <= '0;
        end else if (commit) begin
            r_count <= n_count;
            r_iter  <= n_iter;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (commit) begin
            r_o_valid <= 1'b1;
        end else if (r_o_valid && !i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_ok   <= n_ok;
            r_elem <= n_elem;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_ok          = r_ok;
    assign o_element_out = r_elem;
    assign o_count       = r_count;

`ifndef SYNTHESIS
    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CAPACITY)
        else $error("element count exceeds the number of cells");

    // The set holds no duplicates, so at most one cell matches.
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> $onehot0(match_vec))
        else $error("more than one cell matches the key");

    // An accepted request always moves on to the compare cycle.
    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_MATCH))
        else $error("accepted request did not enter the compare cycle");

    // The count only moves on a commit.
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !commit |=> $stable(r_count))
        else $error("element count changed outside a commit");

    // A stalled result is not overwritten by a new commit.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_stall) |-> !commit)
        else $error("commit while the previous result is stalled");
`endif

endmodule
